/* sv/lfg_pkg.sv */
// ----------------------------------------------------------------------------
// LED effect frame generator package
// Shared request types, mode and state codes, and the fade table function.
// ----------------------------------------------------------------------------
`default_nettype none

package lfg_pkg;

    localparam int LEVEL_W  = 8;
    localparam int PERIOD_W = 16;
    localparam int FADE_W   = 16;
    localparam int CFG_IDX_W = 8;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 8'd3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd30;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned ONE_Q15 = 64'd32768;
    localparam longint unsigned HALF_Q15 = 64'd16384;
    localparam int TAYLOR_TERMS = 7;
    localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_BLINK = 2'd2,
        MODE_FADE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PHASE,
        S_TABLE,
        S_MUL,
        S_NEXT,
        S_MOD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       kind;
        logic [1:0] new_mode;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0]  out_red;
        logic [LEVEL_W-1:0]  out_green;
        logic [LEVEL_W-1:0]  out_blue;
        logic [1:0]          mode_now;
        logic [PERIOD_W-1:0] frame_index;
    } t_out_item;

    // Q1.15 value of one minus sine for an angle x given in Q30 radians.
    function automatic logic [FADE_W-1:0] fade_from_x(longint unsigned x);
        longint unsigned t;
        longint unsigned s;
        t = x;
        s = x;
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            t = (((t * x) >> 30) * x) >> 30;
            t = t / TAYLOR_DIV[k-1];
            if (k[0]) begin
                s = (s >= t) ? s - t : 64'd0;
            end else begin
                s = s + t;
            end
        end
        if (s > ONE_Q30) begin
            s = ONE_Q30;
        end
        s = (s + HALF_Q15) >> 15;
        if (s > ONE_Q15) begin
            s = ONE_Q15;
        end
        return FADE_W'(ONE_Q15 - s);
    endfunction

endpackage

`default_nettype wire

/* sv/led_effect_frame_generator_top.sv */
// ----------------------------------------------------------------------------
// LED effect frame generator
// Produces one RGB color per frame tick request for the off, on, blink and
// fade effects, with a serial divider for the fade phase and count wrap.
// ----------------------------------------------------------------------------
// A frame tick request yields one result; a set-mode request stores the mode,
// clears the frame count and yields none. A tick in off, on or blink mode
// passes through the next-count and completion states; in fade mode it first
// waits in the phase state on the bit-serial phase divider and then in the
// multiply state on the eight-step channel scalers. When the frame count has
// run past a lowered period, the wrap uses the same divider in the modulo
// state. Configuration writes are to be made only while no tick is in
// flight.
`default_nettype none

module led_effect_frame_generator_top
    import lfg_pkg::*;
#(
    parameter int PHASE_STEPS = 256
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [PERIOD_W-1:0]  i_cfg_data
);

    localparam int PIW = $clog2(PHASE_STEPS);
    localparam int NW  = PERIOD_W + PIW;

    logic [LEVEL_W-1:0]  r_red;
    logic [LEVEL_W-1:0]  r_green;
    logic [LEVEL_W-1:0]  r_blue;
    logic [PERIOD_W-1:0] r_period;

    t_state              r_state,       n_state;
    t_mode               r_mode,        n_mode;
    logic [PERIOD_W-1:0] r_frame_count, n_frame_count;
    logic                r_out_valid,   n_out_valid;
    logic [PIW-1:0]      r_phase,       n_phase;
    logic [LEVEL_W-1:0]  r_res_red,     n_res_red;
    logic [LEVEL_W-1:0]  r_res_green,   n_res_green;
    logic [LEVEL_W-1:0]  r_res_blue,    n_res_blue;
    t_out_item           r_out,         n_out;

    logic [FADE_W-1:0]   w_fade_tab [PHASE_STEPS];
    logic [PERIOD_W-1:0] w_per;
    logic [PERIOD_W:0]   w_next;
    logic                w_in_acc;
    logic                w_div_start;
    logic [NW-1:0]       w_div_num;
    logic                w_div_done;
    logic [NW-1:0]       w_div_quot;
    logic [PERIOD_W-1:0] w_div_rem;
    logic                w_mul_start;
    logic [2:0]          w_mul_done;
    logic [LEVEL_W-1:0]  w_lvl_red;
    logic [LEVEL_W-1:0]  w_lvl_green;
    logic [LEVEL_W-1:0]  w_lvl_blue;

    for (genvar p = 0; p < PHASE_STEPS; p++) begin : g_fade
        localparam longint unsigned PP = (p > PHASE_STEPS / 2) ? PHASE_STEPS - p : p;
        localparam longint unsigned X  = (PP * PI_Q30) / PHASE_STEPS;
        localparam logic [FADE_W-1:0] ENTRY = fade_from_x(X);
        assign w_fade_tab[p] = ENTRY;
    end

    assign w_per      = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign w_next     = {1'b0, r_frame_count} + 1'b1;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red    <= '0;
            r_green  <= '0;
            r_blue   <= '0;
            r_period <= PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RED:    r_red    <= i_cfg_data[LEVEL_W-1:0];
                CFG_GREEN:  r_green  <= i_cfg_data[LEVEL_W-1:0];
                CFG_BLUE:   r_blue   <= i_cfg_data[LEVEL_W-1:0];
                CFG_PERIOD: r_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lfg_serial_div #(
        .NUM_W (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_per),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot),
        .o_rem   (w_div_rem)
    );

    lfg_serial_mul u_mul_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_level (r_red),
        .i_fade  (w_fade_tab[r_phase]),
        .o_done  (w_mul_done[0]),
        .o_level (w_lvl_red)
    );

    lfg_serial_mul u_mul_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_level (r_green),
        .i_fade  (w_fade_tab[r_phase]),
        .o_done  (w_mul_done[1]),
        .o_level (w_lvl_green)
    );

    lfg_serial_mul u_mul_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_level (r_blue),
        .i_fade  (w_fade_tab[r_phase]),
        .o_done  (w_mul_done[2]),
        .o_level (w_lvl_blue)
    );

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_frame_count = r_frame_count;
        n_out_valid   = r_out_valid;
        n_phase       = r_phase;
        n_res_red     = r_res_red;
        n_res_green   = r_res_green;
        n_res_blue    = r_res_blue;
        n_out         = r_out;
        w_div_start   = 1'b0;
        w_div_num     = NW'(r_frame_count) * NW'(PHASE_STEPS);
        w_mul_start   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.kind == KIND_SET) begin
                        n_mode        = t_mode'(i_in.new_mode);
                        n_frame_count = '0;
                    end else if (r_mode == MODE_FADE) begin
                        w_div_start = 1'b1;
                        n_state     = S_PHASE;
                    end else begin
                        n_res_red   = '0;
                        n_res_green = '0;
                        n_res_blue  = '0;
                        if (r_mode == MODE_ON ||
                            (r_mode == MODE_BLINK && r_frame_count >= (w_per >> 1))) begin
                            n_res_red   = r_red;
                            n_res_green = r_green;
                            n_res_blue  = r_blue;
                        end
                        n_state = S_NEXT;
                    end
                end
            end
            S_PHASE: begin
                if (w_div_done) begin
                    if (w_div_quot >= NW'(PHASE_STEPS)) begin
                        n_phase = PIW'(PHASE_STEPS - 1);
                    end else begin
                        n_phase = w_div_quot[PIW-1:0];
                    end
                    n_state = S_TABLE;
                end
            end
            S_TABLE: begin
                w_mul_start = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                if (&w_mul_done) begin
                    n_res_red   = w_lvl_red;
                    n_res_green = w_lvl_green;
                    n_res_blue  = w_lvl_blue;
                    n_state     = S_NEXT;
                end
            end
            S_NEXT: begin
                if (w_next < {1'b0, w_per}) begin
                    n_frame_count = w_next[PERIOD_W-1:0];
                    n_state       = S_DONE;
                end else if (w_next == {1'b0, w_per}) begin
                    n_frame_count = '0;
                    if (r_mode != MODE_OFF) begin
                        n_mode = MODE_ON;
                    end
                    n_state = S_DONE;
                end else begin
                    w_div_start = 1'b1;
                    w_div_num   = NW'(w_next);
                    n_state     = S_MOD;
                end
            end
            S_MOD: begin
                if (w_div_done) begin
                    n_frame_count = w_div_rem;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.out_red     = r_res_red;
                    n_out.out_green   = r_res_green;
                    n_out.out_blue    = r_res_blue;
                    n_out.mode_now    = r_mode;
                    n_out.frame_index = r_frame_count;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mode        <= MODE_OFF;
            r_frame_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_mode        <= n_mode;
            r_frame_count <= n_frame_count;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase     <= n_phase;
        r_res_red   <= n_res_red;
        r_res_green <= n_res_green;
        r_res_blue  <= n_res_blue;
        r_out       <= n_out;
    end

    // A set-mode request always leaves the frame count cleared.
    a_set_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in.kind == KIND_SET |=> r_frame_count == '0)
        else $error("frame count not cleared by set-mode request");

    // The divider only reports completion while the controller waits on it.
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_PHASE || r_state == S_MOD))
        else $error("divider finished outside a divide state");

    // A new result is only ever loaded from the completion state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result loaded outside the completion state");

    // Off mode is left only through a set-mode request.
    a_off_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_OFF && !(w_in_acc && i_in.kind == KIND_SET)
        |=> r_mode == MODE_OFF)
        else $error("off mode left without a set-mode request");

endmodule

`default_nettype wire

/* sv/lfg_serial_div.sv */
// ----------------------------------------------------------------------------
// LED effect serial divider
// Restoring divider that produces one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module lfg_serial_div
    import lfg_pkg::*;
#(
    parameter int NUM_W = 24
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_W-1:0]    i_num,
    input  wire logic [PERIOD_W-1:0] i_den,
    output logic                     o_done,
    output logic [NUM_W-1:0]         o_quot,
    output logic [PERIOD_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(NUM_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_quot;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_den;

    logic [PERIOD_W:0]   w_shift;
    logic                w_ge;
    logic [PERIOD_W:0]   w_diff;

    assign w_shift = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[NUM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[PERIOD_W-1:0] : w_shift[PERIOD_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* sv/lfg_serial_mul.sv */
// ----------------------------------------------------------------------------
// LED effect serial channel scaler
// Shift-and-add multiply of one color level by a Q1.15 fade factor, one
// level bit per cycle, followed by rounding and clamping to eight bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lfg_serial_mul
    import lfg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [LEVEL_W-1:0] i_level,
    input  wire logic [FADE_W-1:0]  i_fade,
    output logic                    o_done,
    output logic [LEVEL_W-1:0]      o_level
);

    localparam int ACC_W = LEVEL_W + FADE_W;
    localparam int CNT_W = $clog2(LEVEL_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [LEVEL_W-1:0] r_bits;
    logic [FADE_W-1:0]  r_fade;
    logic [ACC_W-1:0]   r_acc;

    logic [ACC_W:0]     w_round;
    logic [ACC_W-15:0]  w_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(LEVEL_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bits <= i_level;
            r_fade <= i_fade;
            r_acc  <= '0;
        end else if (r_busy) begin
            r_bits <= {r_bits[LEVEL_W-2:0], 1'b0};
            r_acc  <= {r_acc[ACC_W-2:0], 1'b0}
                      + (r_bits[LEVEL_W-1] ? ACC_W'(r_fade) : ACC_W'(0));
        end
    end

    assign w_round  = {1'b0, r_acc} + (ACC_W+1)'(HALF_Q15);
    assign w_scaled = w_round[ACC_W:15];
    assign o_level  = (|w_scaled[ACC_W-15:LEVEL_W]) ? '1 : w_scaled[LEVEL_W-1:0];
    assign o_done   = r_done;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED effect frame generator testbench
// Drives frame tick and set-mode requests through directed phases at fixed
// and random phases at random register settings, predicts every result, and
// checks it against the prediction with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_top;
    import lfg_pkg::*;

    localparam int STEPS         = 256;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_END    = 650;
    localparam int LIMIT_NS      = 2_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PERIOD_W-1:0]  cfg_data = '0;

    t_out_item   pending_frames[$];
    int unsigned fade_gain[STEPS];
    t_mode       eff_mode = MODE_OFF;
    int unsigned eff_count = 0;
    logic [7:0]  lvl_red = '0;
    logic [7:0]  lvl_green = '0;
    logic [7:0]  lvl_blue = '0;
    logic [15:0] period_cfg = PERIOD_RESET;

    int unsigned requests_sent = 0;
    int unsigned mismatches = 0;
    bit          no_idle = 1'b0;
    bit          hold_request = 1'b0;

    led_effect_frame_generator_top #(
        .PHASE_STEPS(STEPS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned gain_for_phase(int unsigned p);
        longint unsigned ang;
        longint unsigned term;
        longint unsigned acc;
        int unsigned     q;
        q = (p > STEPS / 2) ? STEPS - p : p;
        ang = (longint'(q) * PI_Q30) / STEPS;
        term = ang;
        acc = ang;
        for (int k = 1; k <= 7; k++) begin
            term = (((term * ang) >> 30) * ang) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        if (acc > ONE_Q30) begin
            acc = ONE_Q30;
        end
        acc = (acc + HALF_Q15) >> 15;
        if (acc > ONE_Q15) begin
            acc = ONE_Q15;
        end
        return int'(ONE_Q15 - acc);
    endfunction

    function automatic logic [7:0] scale_level(int unsigned lvl, int unsigned gain);
        int unsigned v;
        v = (lvl * gain + 16384) >> 15;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic advance_effect(t_in_item req);
        int unsigned per;
        int unsigned phase;
        int unsigned nxt;
        int unsigned gain;
        t_out_item   want;
        per = (period_cfg == 0) ? 1 : period_cfg;
        if (req.kind == KIND_SET) begin
            eff_mode = t_mode'(req.new_mode);
            eff_count = 0;
            return;
        end
        want = '0;
        case (eff_mode)
            MODE_FADE: begin
                phase = (eff_count * STEPS) / per;
                if (phase > STEPS - 1) begin
                    phase = STEPS - 1;
                end
                gain = fade_gain[phase];
                want.out_red   = scale_level(lvl_red, gain);
                want.out_green = scale_level(lvl_green, gain);
                want.out_blue  = scale_level(lvl_blue, gain);
            end
            MODE_ON, MODE_BLINK: begin
                if (eff_mode == MODE_ON || eff_count >= per / 2) begin
                    want.out_red   = lvl_red;
                    want.out_green = lvl_green;
                    want.out_blue  = lvl_blue;
                end
            end
            default: ;
        endcase
        nxt = eff_count + 1;
        if (nxt == per && eff_mode != MODE_OFF) begin
            eff_mode = MODE_ON;
        end
        eff_count = (nxt % per) & 16'hFFFF;
        want.mode_now    = eff_mode;
        want.frame_index = 16'(eff_count);
        pending_frames.push_back(want);
    endtask

    task automatic send_request(t_in_item req);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!(in_valid && in_ready));
        advance_effect(req);
        requests_sent++;
    endtask

    task automatic send_ticks(int unsigned count);
        t_in_item req;
        for (int unsigned n = 0; n < count; n++) begin
            req.kind     = KIND_TICK;
            req.new_mode = 2'($urandom_range(0, 3));
            send_request(req);
        end
    endtask

    task automatic send_mode(t_mode m);
        t_in_item req;
        req.kind     = KIND_SET;
        req.new_mode = m;
        send_request(req);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [PERIOD_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (index)
            CFG_RED:    lvl_red = data[7:0];
            CFG_GREEN:  lvl_green = data[7:0];
            CFG_BLUE:   lvl_blue = data[7:0];
            CFG_PERIOD: period_cfg = data;
            default: ;
        endcase
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_ticks(1);
        send_mode(MODE_ON);
        send_ticks(1);
    endtask

    task automatic test_each_mode();
        wait_until_idle();
        write_register(CFG_RED, 16'hA5FF);
        write_register(CFG_GREEN, 16'h5A00);
        write_register(CFG_BLUE, 16'h0080);
        write_register(CFG_PERIOD, 16'd3);
        send_mode(MODE_OFF);
        send_ticks(1);
        send_mode(MODE_ON);
        send_ticks(1);
        send_mode(MODE_BLINK);
        send_ticks(3);
        send_mode(MODE_FADE);
        send_ticks(3);
    endtask

    task automatic test_zero_period();
        wait_until_idle();
        write_register(CFG_PERIOD, 16'd0);
        write_register(CFG_UNUSED, 16'hFFFF);
        send_mode(MODE_BLINK);
        send_ticks(1);
        send_mode(MODE_FADE);
        send_ticks(1);
    endtask

    task automatic test_frame_past_period();
        wait_until_idle();
        write_register(CFG_PERIOD, 16'd8);
        send_mode(MODE_FADE);
        send_ticks(5);
        wait_until_idle();
        write_register(CFG_PERIOD, 16'd3);
        send_ticks(2);
    endtask

    task automatic test_random_effects();
        int unsigned phase_no;
        int unsigned phase_start;
        int unsigned per_eff;
        int unsigned roll;
        logic [15:0] per_new;
        phase_no = 0;
        while (requests_sent < RANDOM_END) begin
            wait_until_idle();
            no_idle = (phase_no % 3 == 1);
            write_register(CFG_RED, {8'($urandom), pick_level()});
            write_register(CFG_GREEN, {8'($urandom), pick_level()});
            write_register(CFG_BLUE, {8'($urandom), pick_level()});
            case (phase_no % 8)
                0: per_new = 16'd1;
                1: per_new = 16'd2;
                2: per_new = 16'd0;
                3: per_new = 16'hFFFF;
                4: per_new = 16'($urandom_range(0, 65535));
                default: per_new = 16'($urandom_range(3, 24));
            endcase
            write_register(CFG_PERIOD, per_new);
            if (phase_no % 4 == 3) begin
                write_register(8'($urandom_range(CFG_PERIOD + 1, 255)), 16'($urandom));
            end
            if (phase_no == 2) begin
                hold_request = 1'b1;
            end
            per_eff = (per_new == 0) ? 1 : per_new;
            phase_start = requests_sent;
            while (requests_sent - phase_start < 60 && requests_sent < RANDOM_END) begin
                roll = $urandom_range(0, 9);
                if (roll != 0) begin
                    send_mode(t_mode'($urandom_range(0, 3)));
                end
                if (roll == 1) begin
                    send_mode(t_mode'($urandom_range(0, 3)));
                end
                send_ticks($urandom_range(0, (per_eff < 30) ? per_eff + 2 : 30));
            end
            phase_no++;
        end
        no_idle = 1'b0;
    endtask

    initial begin : results_sink
        int unsigned gap;
        forever begin
            if (hold_request) begin
                out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
                hold_request = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: r=%0d g=%0d b=%0d mode=%0d frame=%0d",
                             out_item.out_red, out_item.out_green, out_item.out_blue,
                             out_item.mode_now, out_item.frame_index);
                end
            end else begin
                want = pending_frames.pop_front();
                if (out_item.out_red !== want.out_red
                        || out_item.out_green !== want.out_green
                        || out_item.out_blue !== want.out_blue
                        || out_item.mode_now !== want.mode_now
                        || out_item.frame_index !== want.frame_index) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected r=%0d g=%0d b=%0d mode=%0d frame=%0d",
                                 want.out_red, want.out_green, want.out_blue,
                                 want.mode_now, want.frame_index);
                        $display("          actual   r=%0d g=%0d b=%0d mode=%0d frame=%0d",
                                 out_item.out_red, out_item.out_green, out_item.out_blue,
                                 out_item.mode_now, out_item.frame_index);
                    end
                end
            end
        end
    end

    initial begin : main
        for (int p = 0; p < STEPS; p++) begin
            fade_gain[p] = gain_for_phase(p);
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_each_mode();
        test_zero_period();
        test_frame_past_period();
        test_random_effects();
        wait_until_idle();
        if (mismatches == 0 && pending_frames.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
